@@ hw/rtl/seu_pkg.sv @@
// shared types, constants and character functions of the escaped-string utf-8 decoder
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package seu_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_NUMERIC  = 2'd0;
  localparam logic [1:0] REG_STRING   = 2'd1;
  localparam logic [1:0] REG_RESERVED = 2'd2;

  // error codes carried with a result
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_HEX   = 2'd1;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // code point limits for the utf-8 length choice
  localparam logic [31:0] CP_MAX_1B  = 32'h0000_007F;
  localparam logic [31:0] CP_MAX_2B  = 32'h0000_07FF;
  localparam logic [31:0] CP_MAX_3B  = 32'h0000_FFFF;
  localparam logic [31:0] CP_MAX_ALL = 32'h0010_FFFF;

  // utf-8 lead and continuation marks
  localparam logic [7:0] UTF8_LEAD2 = 8'b1100_0000;
  localparam logic [7:0] UTF8_LEAD3 = 8'b1110_0000;
  localparam logic [7:0] UTF8_LEAD4 = 8'b1111_0000;
  localparam logic [7:0] UTF8_CONT  = 8'b1000_0000;

  // characters with a role in the escape syntax
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_UPPER_U = 8'h55;

  // hex digit counts of the two numeric escapes
  localparam logic [3:0] HEX_DIGITS_SHORT = 4'd4;
  localparam logic [3:0] HEX_DIGITS_LONG  = 4'd8;

  // most words one input byte can produce
  localparam int MaxResults = 4;

  // escape parser state
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_BSLASH = 3'b010,
    PH_HEX    = 3'b100
  } phase_t;

  // enables from the register file
  typedef struct packed {
    logic numeric_on;
    logic str_on;
    logic reserved_on;
  } cfg_t;

  // all result words caused by one input byte
  typedef struct packed {
    logic [2:0]                  count;
    logic [MaxResults-1:0][7:0]  bytes;
    logic                        byte_valid;
    logic [1:0]                  error_code;
    logic                        eos;
  } res_group_t;

  // string escape letter to byte, hit flag on top
  function automatic logic [8:0] str_escape(input logic [7:0] c);
    logic [8:0] r;
    r = '0;
    unique case (c)
      8'h74:   r = {1'b1, 8'h09};
      8'h62:   r = {1'b1, 8'h08};
      8'h6E:   r = {1'b1, 8'h0A};
      8'h72:   r = {1'b1, 8'h0D};
      8'h66:   r = {1'b1, 8'h0C};
      8'h22:   r = {1'b1, 8'h22};
      8'h27:   r = {1'b1, 8'h27};
      8'h5C:   r = {1'b1, 8'h5C};
      default: r = '0;
    endcase
    return r;
  endfunction

  // reserved punctuation that may be escaped
  function automatic logic is_reserved(input logic [7:0] c);
    logic r;
    r = 1'b0;
    unique case (c)
      8'h7E, 8'h2E, 8'h2D, 8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
      8'h2B, 8'h2C, 8'h3B, 8'h3D, 8'h2F, 8'h3F, 8'h23, 8'h40, 8'h25, 8'h5F:
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // hex digit value, ok flag on top
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/string_escape_utf8_decoder_top.sv @@
// escaped-string decoder: one input byte per word, 0 to 4 unescaped utf-8 result words out
// a byte passes the input register, then the result register, before its first result word is valid
// throughput: one byte per cycle while each yields at most one word and m_tready is high; a byte
//   with n words holds the result register until its last word is taken, bytes with no word pass without a result slot
// reset: synchronous rst clears the escape state and restores the enable registers
`timescale 1ns / 1ps

module string_escape_utf8_decoder_top import seu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // in_byte
  input  logic        s_tlast,    // in_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // out_byte
  output logic [3:0]  m_tuser,    // byte_valid, error_code[1:0], last_of_item
  output logic        m_tlast     // end_of_string
);

  cfg_t       cfg;
  res_group_t grp;
  logic       grp_valid;
  logic       grp_ready;

  // enable registers
  seu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register and decode
  seu_dec u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp)
  );

  // result register and word serializer
  seu_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ hw/rtl/seu_cfg.sv @@
// apb register file for the three escape enables
// depends on seu_pkg
`timescale 1ns / 1ps

module seu_cfg import seu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes, only bit 0 kept
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.numeric_on  <= 1'b1;
      cfg.str_on      <= 1'b1;
      cfg.reserved_on <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NUMERIC:  cfg.numeric_on  <= pwdata[0];
        REG_STRING:   cfg.str_on      <= pwdata[0];
        REG_RESERVED: cfg.reserved_on <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_NUMERIC:  prdata[0] = cfg.numeric_on;
      REG_STRING:   prdata[0] = cfg.str_on;
      REG_RESERVED: prdata[0] = cfg.reserved_on;
      default:      prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/seu_dec.sv @@
// input register, escape state and single-pass decode of one byte into a result group
// depends on seu_pkg
`timescale 1ns / 1ps

module seu_dec import seu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // in_byte
  input  logic       s_tlast,     // in_last
  output logic       grp_valid,
  input  logic       grp_ready,
  output res_group_t grp
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // escape state
  phase_t      phase, phase_next;
  logic [3:0]  hex_left, hex_left_next;
  logic [31:0] accum, accum_next;
  logic        discarding, discarding_next;

  logic        advance;
  logic [4:0]  hx;
  logic [8:0]  se;
  logic [31:0] acc_shift;
  logic [3:0]  left_dec;
  logic        raise;
  logic [1:0]  raise_code;

  assign grp_valid = in_valid && (grp.count != 3'd0);
  assign advance   = in_valid && ((grp.count == 3'd0) || grp_ready);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // decode of the held byte against the escape state
  always_comb begin
    hx              = hex_digit(in_byte);
    se              = str_escape(in_byte);
    acc_shift       = {accum[27:0], hx[3:0]};
    left_dec        = hex_left - 4'd1;
    grp             = '0;
    grp.byte_valid  = 1'b1;
    grp.eos         = in_last;
    phase_next      = phase;
    hex_left_next   = hex_left;
    accum_next      = accum;
    discarding_next = discarding;
    raise           = 1'b0;
    raise_code      = ERR_NONE;

    if (discarding) begin
      if (in_last) begin
        grp.count       = 3'd1;
        grp.byte_valid  = 1'b0;
        discarding_next = 1'b0;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (in_byte != CH_BSLASH) begin
            grp.count    = 3'd1;
            grp.bytes[0] = in_byte;
          end else if (in_last) begin
            grp.count    = 3'd1;
            grp.bytes[0] = CH_BSLASH;
          end else begin
            phase_next = PH_BSLASH;
          end
        end
        PH_BSLASH: begin
          phase_next = PH_IDLE;
          if (cfg.numeric_on && (in_byte == CH_LOWER_U || in_byte == CH_UPPER_U)) begin
            if (in_last) begin
              raise      = 1'b1;
              raise_code = ERR_TRUNCATED;
            end else begin
              phase_next    = PH_HEX;
              hex_left_next = (in_byte == CH_LOWER_U) ? HEX_DIGITS_SHORT : HEX_DIGITS_LONG;
              accum_next    = '0;
            end
          end else if (cfg.str_on && se[8]) begin
            grp.count    = 3'd1;
            grp.bytes[0] = se[7:0];
          end else if (cfg.reserved_on && is_reserved(in_byte)) begin
            grp.count    = 3'd1;
            grp.bytes[0] = in_byte;
          end else begin
            // unknown escape: backslash out, then the byte afresh
            grp.bytes[0] = CH_BSLASH;
            if (in_byte != CH_BSLASH) begin
              grp.count    = 3'd2;
              grp.bytes[1] = in_byte;
            end else if (in_last) begin
              grp.count    = 3'd2;
              grp.bytes[1] = CH_BSLASH;
            end else begin
              grp.count  = 3'd1;
              phase_next = PH_BSLASH;
            end
          end
        end
        PH_HEX: begin
          if (!hx[4]) begin
            raise      = 1'b1;
            raise_code = ERR_BAD_HEX;
          end else begin
            accum_next    = acc_shift;
            hex_left_next = left_dec;
            if (left_dec == 4'd0) begin
              if (acc_shift > CP_MAX_ALL) begin
                raise      = 1'b1;
                raise_code = ERR_TOO_LARGE;
              end else begin
                phase_next = PH_IDLE;
                accum_next = '0;
                // utf-8 encoding by code point range
                if (acc_shift <= CP_MAX_1B) begin
                  grp.count    = 3'd1;
                  grp.bytes[0] = acc_shift[7:0];
                end else if (acc_shift <= CP_MAX_2B) begin
                  grp.count    = 3'd2;
                  grp.bytes[0] = UTF8_LEAD2 | {3'b000, acc_shift[10:6]};
                  grp.bytes[1] = UTF8_CONT | {2'b00, acc_shift[5:0]};
                end else if (acc_shift <= CP_MAX_3B) begin
                  grp.count    = 3'd3;
                  grp.bytes[0] = UTF8_LEAD3 | {4'b0000, acc_shift[15:12]};
                  grp.bytes[1] = UTF8_CONT | {2'b00, acc_shift[11:6]};
                  grp.bytes[2] = UTF8_CONT | {2'b00, acc_shift[5:0]};
                end else begin
                  grp.count    = 3'd4;
                  grp.bytes[0] = UTF8_LEAD4 | {5'b00000, acc_shift[20:18]};
                  grp.bytes[1] = UTF8_CONT | {2'b00, acc_shift[17:12]};
                  grp.bytes[2] = UTF8_CONT | {2'b00, acc_shift[11:6]};
                  grp.bytes[3] = UTF8_CONT | {2'b00, acc_shift[5:0]};
                end
              end
            end else if (in_last) begin
              raise      = 1'b1;
              raise_code = ERR_TRUNCATED;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    // malformed numeric escape: one error word, then drop to end of string
    if (raise) begin
      grp.count       = 3'd1;
      grp.bytes       = '0;
      grp.byte_valid  = 1'b0;
      grp.error_code  = raise_code;
      phase_next      = PH_IDLE;
      hex_left_next   = '0;
      accum_next      = '0;
      discarding_next = !in_last;
    end

    // end of string returns everything to idle
    if (in_last) begin
      phase_next      = PH_IDLE;
      hex_left_next   = '0;
      accum_next      = '0;
      discarding_next = 1'b0;
    end
  end

  // state update when the byte leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hex_left   <= '0;
      accum      <= '0;
      discarding <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      hex_left   <= hex_left_next;
      accum      <= accum_next;
      discarding <= discarding_next;
    end
  end

  hex_left_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEX) |-> (hex_left != 4'd0 && hex_left <= HEX_DIGITS_LONG))
    else $error("hex digit count out of range while collecting digits");

  discard_idle: assert property (@(posedge clk) disable iff (rst)
    discarding |-> (phase == PH_IDLE && hex_left == 4'd0))
    else $error("escape state left pending while discarding");

  group_shape: assert property (@(posedge clk) disable iff (rst)
    (grp_valid && !grp.byte_valid) |-> (grp.count == 3'd1))
    else $error("error word not alone in its group");

endmodule

@@ hw/rtl/seu_ser.sv @@
// result register that holds one group and hands it out one word per cycle while m_tready is high
// depends on seu_pkg
`timescale 1ns / 1ps

module seu_ser import seu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       grp_valid,
  output logic       grp_ready,
  input  res_group_t grp,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // out_byte
  output logic [3:0] m_tuser,     // byte_valid, error_code[1:0], last_of_item
  output logic       m_tlast      // end_of_string
);

  logic [2:0]                 rem;
  logic [MaxResults-1:0][7:0] bytes;
  logic                       byte_valid;
  logic [1:0]                 error_code;
  logic                       eos;
  logic                       beat;
  logic                       load;
  logic                       final_word;

  assign final_word = (rem == 3'd1);
  assign beat       = m_tvalid && m_tready;
  assign grp_ready  = (rem == 3'd0) || (final_word && m_tready);
  assign load       = grp_valid && grp_ready;

  assign m_tvalid = (rem != 3'd0);
  assign m_tdata  = bytes[0];
  assign m_tuser  = {final_word, error_code, byte_valid};
  assign m_tlast  = eos && final_word;

  // word count
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= grp.count;
    end else if (beat) begin
      rem <= rem - 3'd1;
    end
  end

  // payload, shifted down one byte per word taken
  always_ff @(posedge clk) begin
    if (load) begin
      bytes      <= grp.bytes;
      byte_valid <= grp.byte_valid;
      error_code <= grp.error_code;
      eos        <= grp.eos;
    end else if (beat) begin
      bytes <= {8'h00, bytes[MaxResults-1:1]};
    end
  end

  rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= 3'(MaxResults))
    else $error("result count above group size");

  load_count: assert property (@(posedge clk) disable iff (rst)
    load |=> (rem == $past(grp.count)))
    else $error("result count not taken from loaded group");

endmodule
